// ===== hw/rtl/ppm_pkg.sv =====
package ppm_pkg;

    // Check periods and current-warning persistence
    localparam logic [3:0] SOIL_PERIOD   = 4'd10;
    localparam logic [4:0] TEMP_PERIOD   = 5'd20;
    localparam logic [7:0] PERSIST_COUNT = 8'd3;
    localparam logic [7:0] PERSIST_MAX   = 8'd255;

    // Field widths
    localparam int unsigned CUR_W  = 16;
    localparam int unsigned SOIL_W = 7;
    localparam int unsigned TEMP_W = 10;
    localparam int unsigned IN_W   = 40;
    localparam int unsigned OUT_W  = 24;
    localparam int unsigned CFG_AW = 4;
    localparam int unsigned CFG_DW = 16;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_SOIL_WARN = 4'd0;
    localparam logic [CFG_AW-1:0] REG_SOIL_CRIT = 4'd1;
    localparam logic [CFG_AW-1:0] REG_SOIL_REC  = 4'd2;
    localparam logic [CFG_AW-1:0] REG_CUR_WARN  = 4'd3;
    localparam logic [CFG_AW-1:0] REG_CUR_CRIT  = 4'd4;
    localparam logic [CFG_AW-1:0] REG_TEMP_WARN = 4'd5;
    localparam logic [CFG_AW-1:0] REG_TEMP_CRIT = 4'd6;
    localparam logic [CFG_AW-1:0] REG_TEMP_REC  = 4'd7;

    // Register reset values
    localparam logic [SOIL_W-1:0]        RST_SOIL_WARN = 7'd80;
    localparam logic [SOIL_W-1:0]        RST_SOIL_CRIT = 7'd90;
    localparam logic [SOIL_W-1:0]        RST_SOIL_REC  = 7'd70;
    localparam logic [CUR_W-1:0]         RST_CUR_WARN  = 16'd1500;
    localparam logic [CUR_W-1:0]         RST_CUR_CRIT  = 16'd2500;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_WARN = 10'sd50;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_CRIT = 10'sd60;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_REC  = 10'sd45;

    // Commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // Classification levels
    localparam logic [1:0] LVL_OK   = 2'd0;
    localparam logic [1:0] LVL_WARN = 2'd1;
    localparam logic [1:0] LVL_CRIT = 2'd2;

    // System states
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_LOCKED = 2'd1;
    localparam logic [1:0] MODE_FAULT  = 2'd2;

    // Fault / lock bit positions
    localparam int unsigned FB_WATER = 0;
    localparam int unsigned FB_CUR   = 1;
    localparam int unsigned FB_HEAT  = 2;

    // Lamp bit positions
    localparam int unsigned LAMP_YEL = 0;
    localparam int unsigned LAMP_RED = 1;

    // Beep bit positions
    localparam int unsigned BEEP_SHUT  = 0;
    localparam int unsigned BEEP_WATER = 1;
    localparam int unsigned BEEP_SOIL  = 2;
    localparam int unsigned BEEP_CUR   = 3;
    localparam int unsigned BEEP_TEMP  = 4;

endpackage

// ===== hw/rtl/pump_protection_monitor_unit.sv =====
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/s_axis_tready  tdata: pump_cur, soil_moist, temp_c
//                                              tuser: cmd
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata: result fields
// cfg        in   i_cfg_we (no wait)           i_cfg_addr, i_cfg_wdata
//
// One word per cycle sustained while m_axis_tready stays high; a word passes through the
// input register and then the result register before its result is valid on m_axis.
// The check logic between the two registers is a few compares and adds.
// i_rst_n is synchronous: it clears all monitor state and loads threshold defaults.
// While the result register is held, the input register keeps one more word;
// s_axis_tready drops only when both are full.
module pump_protection_monitor_unit import ppm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [15:0] pump_cur, [22:16] soil_moist, [32:23] temp_c, [39:33] zero
    input  logic [IN_W-1:0]     s_axis_tdata,
    // [0] cmd
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [1:0] system_state, [4:2] fault_bits, [5] pump_locked, [6] relay_off_pulse,
    // [7] yellow_led, [8] red_led, [13:9] beep_mask, [15:14] soil_level,
    // [17:16] current_level, [19:18] temp_level, [23:20] zero
    output logic [OUT_W-1:0]    m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata
);

    // thresholds
    logic [SOIL_W-1:0]        r_soil_warn, r_soil_crit, r_soil_rec;
    logic [CUR_W-1:0]         r_cur_warn, r_cur_crit;
    logic signed [TEMP_W-1:0] r_temp_warn, r_temp_crit, r_temp_rec;

    // input register
    logic                     r_in_valid;
    logic                     r_in_cmd;
    logic [CUR_W-1:0]         r_in_cur;
    logic [SOIL_W-1:0]        r_in_soil;
    logic signed [TEMP_W-1:0] r_in_temp;

    // monitor state
    logic [2:0] r_fault, n_fault;
    logic [2:0] r_lock, n_lock;
    logic       r_rst_req, n_rst_req;
    logic [7:0] r_persist, n_persist;
    logic [3:0] r_soil_div, n_soil_div;
    logic [4:0] r_temp_div, n_temp_div;
    logic [1:0] r_lvl_soil, n_lvl_soil;
    logic [1:0] r_lvl_cur, n_lvl_cur;
    logic [1:0] r_lvl_temp, n_lvl_temp;
    logic [1:0] r_lamp, n_lamp;

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    logic             advance;
    logic [CUR_W:0]   cur_mag;
    logic             relay;
    logic [4:0]       beep;
    logic [1:0]       mode;
    logic [3:0]       soil_div_inc;
    logic [4:0]       temp_div_inc;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign cur_mag = r_in_cur[CUR_W-1] ? ((CUR_W+1)'(1) << CUR_W) - {1'b0, r_in_cur}
                                       : {1'b0, r_in_cur};
    assign soil_div_inc = r_soil_div + 4'd1;
    assign temp_div_inc = r_temp_div + 5'd1;

    // Checks run in order current, soil, temperature; each sees what the
    // earlier one left.
    always_comb begin
        n_fault    = r_fault;
        n_lock     = r_lock;
        n_rst_req  = r_rst_req;
        n_persist  = r_persist;
        n_soil_div = r_soil_div;
        n_temp_div = r_temp_div;
        n_lvl_soil = r_lvl_soil;
        n_lvl_cur  = r_lvl_cur;
        n_lvl_temp = r_lvl_temp;
        n_lamp     = r_lamp;
        relay      = 1'b0;
        beep       = '0;

        if (r_in_cmd == CMD_RESET) begin
            if (r_rst_req) begin
                n_rst_req        = 1'b0;
                n_persist        = '0;
                n_lock[FB_CUR]   = 1'b0;
                n_fault[FB_CUR]  = 1'b0;
                n_lamp[LAMP_RED] = 1'b0;
            end
        end else begin
            // current
            if (cur_mag > {1'b0, r_cur_crit}) begin
                n_lvl_cur = LVL_CRIT;
                if (!n_rst_req) begin
                    relay            = 1'b1;
                    n_lamp[LAMP_YEL] = 1'b0;
                    n_lamp[LAMP_RED] = 1'b1;
                    beep[BEEP_SHUT]  = 1'b1;
                    n_lock[FB_CUR]   = 1'b1;
                    n_fault[FB_CUR]  = 1'b1;
                    n_rst_req        = 1'b1;
                    n_persist        = '0;
                end
            end else if (cur_mag > {1'b0, r_cur_warn}) begin
                n_lvl_cur = LVL_WARN;
                if (n_persist != PERSIST_MAX) begin
                    n_persist = n_persist + 8'd1;
                end
                if (n_persist >= PERSIST_COUNT) begin
                    n_lamp[LAMP_YEL] = 1'b1;
                    if (r_lvl_cur != LVL_WARN) begin
                        beep[BEEP_CUR] = 1'b1;
                    end
                end
            end else begin
                n_lvl_cur = LVL_OK;
                n_persist = '0;
                if (!n_fault[FB_CUR]) begin
                    n_lock[FB_CUR]   = 1'b0;
                    n_lamp[LAMP_YEL] = 1'b0;
                end
            end

            // soil
            n_soil_div = soil_div_inc;
            if (soil_div_inc >= SOIL_PERIOD) begin
                n_soil_div = '0;
                if (r_in_soil > r_soil_crit) begin
                    n_lvl_soil = LVL_CRIT;
                    if (!n_rst_req) begin
                        relay             = 1'b1;
                        n_lock[FB_WATER]  = 1'b1;
                        n_fault[FB_WATER] = 1'b1;
                    end
                    n_lamp[LAMP_YEL] = 1'b0;
                    n_lamp[LAMP_RED] = 1'b1;
                    if (r_lvl_soil != LVL_CRIT) begin
                        beep[BEEP_WATER] = 1'b1;
                    end
                end else if (r_in_soil <= r_soil_rec && n_fault[FB_WATER]) begin
                    n_fault[FB_WATER] = 1'b0;
                    n_lock[FB_WATER]  = 1'b0;
                    n_lvl_soil        = LVL_OK;
                    n_lamp[LAMP_RED]  = 1'b0;
                end else if (r_in_soil > r_soil_warn) begin
                    n_lvl_soil       = LVL_WARN;
                    n_lamp[LAMP_YEL] = 1'b1;
                    if (r_lvl_soil != LVL_WARN) begin
                        beep[BEEP_SOIL] = 1'b1;
                    end
                end else begin
                    n_lvl_soil = LVL_OK;
                    if (!n_fault[FB_WATER]) begin
                        n_lock[FB_WATER] = 1'b0;
                        n_lamp[LAMP_YEL] = 1'b0;
                    end
                end
            end

            // temperature
            n_temp_div = temp_div_inc;
            if (temp_div_inc >= TEMP_PERIOD) begin
                n_temp_div = '0;
                if (r_in_temp > r_temp_crit) begin
                    n_lvl_temp = LVL_CRIT;
                    if (!n_rst_req) begin
                        relay            = 1'b1;
                        n_lamp[LAMP_YEL] = 1'b0;
                        n_lamp[LAMP_RED] = 1'b1;
                        beep[BEEP_SHUT]  = 1'b1;
                        n_lock[FB_HEAT]  = 1'b1;
                        n_fault[FB_HEAT] = 1'b1;
                    end
                end else if (r_in_temp <= r_temp_rec && n_fault[FB_HEAT]) begin
                    n_fault[FB_HEAT] = 1'b0;
                    n_lock[FB_HEAT]  = 1'b0;
                    n_lvl_temp       = LVL_OK;
                    n_lamp[LAMP_RED] = 1'b0;
                end else if (r_in_temp > r_temp_warn) begin
                    n_lvl_temp       = LVL_WARN;
                    n_lamp[LAMP_YEL] = 1'b1;
                    if (r_lvl_temp != LVL_WARN) begin
                        beep[BEEP_TEMP] = 1'b1;
                    end
                end else begin
                    n_lvl_temp = LVL_OK;
                    if (!n_fault[FB_HEAT]) begin
                        n_lock[FB_HEAT]  = 1'b0;
                        n_lamp[LAMP_YEL] = 1'b0;
                    end
                end
            end
        end

        if (n_fault != '0) begin
            mode = MODE_FAULT;
        end else if (n_lock != '0) begin
            mode = MODE_LOCKED;
        end else begin
            mode = MODE_NORMAL;
        end

        n_out_data = {4'b0000, n_lvl_temp, n_lvl_cur, n_lvl_soil, beep,
                      n_lamp[LAMP_RED], n_lamp[LAMP_YEL], relay,
                      (n_lock != '0), n_fault, mode};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soil_warn <= RST_SOIL_WARN;
            r_soil_crit <= RST_SOIL_CRIT;
            r_soil_rec  <= RST_SOIL_REC;
            r_cur_warn  <= RST_CUR_WARN;
            r_cur_crit  <= RST_CUR_CRIT;
            r_temp_warn <= RST_TEMP_WARN;
            r_temp_crit <= RST_TEMP_CRIT;
            r_temp_rec  <= RST_TEMP_REC;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SOIL_WARN: r_soil_warn <= i_cfg_wdata[SOIL_W-1:0];
                REG_SOIL_CRIT: r_soil_crit <= i_cfg_wdata[SOIL_W-1:0];
                REG_SOIL_REC:  r_soil_rec  <= i_cfg_wdata[SOIL_W-1:0];
                REG_CUR_WARN:  r_cur_warn  <= i_cfg_wdata[CUR_W-1:0];
                REG_CUR_CRIT:  r_cur_crit  <= i_cfg_wdata[CUR_W-1:0];
                REG_TEMP_WARN: r_temp_warn <= $signed(i_cfg_wdata[TEMP_W-1:0]);
                REG_TEMP_CRIT: r_temp_crit <= $signed(i_cfg_wdata[TEMP_W-1:0]);
                REG_TEMP_REC:  r_temp_rec  <= $signed(i_cfg_wdata[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_cur  <= s_axis_tdata[15:0];
            r_in_soil <= s_axis_tdata[22:16];
            r_in_temp <= $signed(s_axis_tdata[32:23]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault    <= '0;
            r_lock     <= '0;
            r_rst_req  <= 1'b0;
            r_persist  <= '0;
            r_soil_div <= '0;
            r_temp_div <= '0;
            r_lvl_soil <= LVL_OK;
            r_lvl_cur  <= LVL_OK;
            r_lvl_temp <= LVL_OK;
            r_lamp     <= '0;
        end else if (advance) begin
            r_fault    <= n_fault;
            r_lock     <= n_lock;
            r_rst_req  <= n_rst_req;
            r_persist  <= n_persist;
            r_soil_div <= n_soil_div;
            r_temp_div <= n_temp_div;
            r_lvl_soil <= n_lvl_soil;
            r_lvl_cur  <= n_lvl_cur;
            r_lvl_temp <= n_lvl_temp;
            r_lamp     <= n_lamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    // A latched fault always holds its pump lock.
    a_fault_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault & ~r_lock) == 3'b000)
        else $error("fault latched without lock");

    // The manual-reset requirement and the overcurrent fault move together.
    a_rst_req_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rst_req == r_fault[FB_CUR])
        else $error("reset requirement out of step with overcurrent fault");

    // A relay-off word always reports a fault state.
    a_relay_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[6] |-> r_out_data[1:0] == MODE_FAULT)
        else $error("relay pulse without fault");

    // Monitor state moves only when a word passes to the result register.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_soil_div) && $stable(r_temp_div))
        else $error("dividers moved without a word");
`endif

endmodule

// ===== test/ppm_result_checker.sv =====
module ppm_result_checker import ppm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    // [15:0] pump_cur, [22:16] soil_moist, [32:23] temp_c, [39:33] zero
    input  logic [IN_W-1:0]   i_s_tdata,
    // [0] cmd
    input  logic              i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    // [1:0] system_state, [4:2] fault_bits, [5] pump_locked, [6] relay_off_pulse,
    // [7] yellow_led, [8] red_led, [13:9] beep_mask, [15:14] soil_level,
    // [17:16] current_level, [19:18] temp_level, [23:20] zero
    input  logic [OUT_W-1:0]  i_m_tdata,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output int                o_pending,
    output int                o_fail_count
);

    typedef struct packed {
        logic [3:0] pad;
        logic [1:0] temp_level;
        logic [1:0] current_level;
        logic [1:0] soil_level;
        logic [4:0] beep_mask;
        logic       red_led;
        logic       yellow_led;
        logic       relay_off_pulse;
        logic       pump_locked;
        logic [2:0] fault_bits;
        logic [1:0] system_state;
    } status_word_t;

    // thresholds
    logic [SOIL_W-1:0]        soil_warn_r, soil_crit_r, soil_rec_r;
    logic [CUR_W-1:0]         cur_warn_r, cur_crit_r;
    logic signed [TEMP_W-1:0] temp_warn_r, temp_crit_r, temp_rec_r;

    // monitor state
    logic [2:0] fault_q, lock_q;
    logic       rst_req_q;
    logic [7:0] persist_q;
    logic [3:0] soil_div_q;
    logic [4:0] temp_div_q;
    logic [1:0] soil_lvl_q, cur_lvl_q, temp_lvl_q;
    logic [1:0] lamp_q;

    status_word_t predicted_status_q[$];
    status_word_t want, got;
    int           fail_count = 0;

    task automatic shut_pump(inout logic relay, inout logic [4:0] beep);
        relay              = 1'b1;
        lamp_q[LAMP_YEL]   = 1'b0;
        lamp_q[LAMP_RED]   = 1'b1;
        beep[BEEP_SHUT]    = 1'b1;
    endtask

    task automatic predict_status(input logic cmd, input logic [CUR_W-1:0] cur,
                                  input logic [SOIL_W-1:0] soil,
                                  input logic signed [TEMP_W-1:0] temp,
                                  output status_word_t res);
        logic       relay;
        logic [4:0] beep;
        logic [16:0] mag;
        logic [1:0] lvl;
        relay = 1'b0;
        beep  = '0;
        if (cmd == CMD_RESET) begin
            if (rst_req_q) begin
                rst_req_q        = 1'b0;
                persist_q        = '0;
                lock_q[FB_CUR]   = 1'b0;
                fault_q[FB_CUR]  = 1'b0;
                lamp_q[LAMP_RED] = 1'b0;
            end
        end else begin
            // current: magnitude of a signed sample, -32768 maps to 32768
            mag = cur[CUR_W-1] ? (17'h10000 - {1'b0, cur}) : {1'b0, cur};
            if (mag > {1'b0, cur_crit_r}) begin
                lvl = LVL_CRIT;
                if (!rst_req_q) begin
                    shut_pump(relay, beep);
                    lock_q[FB_CUR]  = 1'b1;
                    fault_q[FB_CUR] = 1'b1;
                    rst_req_q       = 1'b1;
                    persist_q       = '0;
                end
            end else if (mag > {1'b0, cur_warn_r}) begin
                lvl = LVL_WARN;
                if (persist_q != PERSIST_MAX) persist_q = persist_q + 8'd1;
                if (persist_q >= PERSIST_COUNT) begin
                    lamp_q[LAMP_YEL] = 1'b1;
                    if (cur_lvl_q != LVL_WARN) beep[BEEP_CUR] = 1'b1;
                end
            end else begin
                lvl       = LVL_OK;
                persist_q = '0;
                if (!fault_q[FB_CUR]) begin
                    lock_q[FB_CUR]   = 1'b0;
                    lamp_q[LAMP_YEL] = 1'b0;
                end
            end
            cur_lvl_q = lvl;

            soil_div_q = soil_div_q + 4'd1;
            if (soil_div_q >= SOIL_PERIOD) begin
                soil_div_q = '0;
                lvl = (soil > soil_crit_r) ? LVL_CRIT : (soil > soil_warn_r) ? LVL_WARN : LVL_OK;
                if (lvl == LVL_CRIT) begin
                    if (!rst_req_q) begin
                        relay             = 1'b1;
                        lock_q[FB_WATER]  = 1'b1;
                        fault_q[FB_WATER] = 1'b1;
                    end
                    // lamps follow soil even while a manual reset is pending
                    lamp_q[LAMP_YEL] = 1'b0;
                    lamp_q[LAMP_RED] = 1'b1;
                    if (soil_lvl_q != LVL_CRIT) beep[BEEP_WATER] = 1'b1;
                end else if (soil <= soil_rec_r && fault_q[FB_WATER]) begin
                    fault_q[FB_WATER] = 1'b0;
                    lock_q[FB_WATER]  = 1'b0;
                    lvl               = LVL_OK;
                    lamp_q[LAMP_RED]  = 1'b0;
                end else if (lvl == LVL_WARN) begin
                    lamp_q[LAMP_YEL] = 1'b1;
                    if (soil_lvl_q != LVL_WARN) beep[BEEP_SOIL] = 1'b1;
                end else if (!fault_q[FB_WATER]) begin
                    lock_q[FB_WATER] = 1'b0;
                    lamp_q[LAMP_YEL] = 1'b0;
                end
                soil_lvl_q = lvl;
            end

            temp_div_q = temp_div_q + 5'd1;
            if (temp_div_q >= TEMP_PERIOD) begin
                temp_div_q = '0;
                lvl = (temp > temp_crit_r) ? LVL_CRIT : (temp > temp_warn_r) ? LVL_WARN : LVL_OK;
                if (lvl == LVL_CRIT) begin
                    if (!rst_req_q) begin
                        shut_pump(relay, beep);
                        lock_q[FB_HEAT]  = 1'b1;
                        fault_q[FB_HEAT] = 1'b1;
                    end
                end else if (temp <= temp_rec_r && fault_q[FB_HEAT]) begin
                    fault_q[FB_HEAT] = 1'b0;
                    lock_q[FB_HEAT]  = 1'b0;
                    lvl              = LVL_OK;
                    lamp_q[LAMP_RED] = 1'b0;
                end else if (lvl == LVL_WARN) begin
                    lamp_q[LAMP_YEL] = 1'b1;
                    if (temp_lvl_q != LVL_WARN) beep[BEEP_TEMP] = 1'b1;
                end else if (!fault_q[FB_HEAT]) begin
                    lock_q[FB_HEAT]  = 1'b0;
                    lamp_q[LAMP_YEL] = 1'b0;
                end
                temp_lvl_q = lvl;
            end
        end

        res.pad             = '0;
        res.temp_level      = temp_lvl_q;
        res.current_level   = cur_lvl_q;
        res.soil_level      = soil_lvl_q;
        res.beep_mask       = beep;
        res.red_led         = lamp_q[LAMP_RED];
        res.yellow_led      = lamp_q[LAMP_YEL];
        res.relay_off_pulse = relay;
        res.pump_locked     = |lock_q;
        res.fault_bits      = fault_q;
        res.system_state    = (fault_q != '0) ? MODE_FAULT :
                              (lock_q != '0) ? MODE_LOCKED : MODE_NORMAL;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            soil_warn_r = RST_SOIL_WARN;
            soil_crit_r = RST_SOIL_CRIT;
            soil_rec_r  = RST_SOIL_REC;
            cur_warn_r  = RST_CUR_WARN;
            cur_crit_r  = RST_CUR_CRIT;
            temp_warn_r = RST_TEMP_WARN;
            temp_crit_r = RST_TEMP_CRIT;
            temp_rec_r  = RST_TEMP_REC;
            fault_q     = '0;
            lock_q      = '0;
            rst_req_q   = 1'b0;
            persist_q   = '0;
            soil_div_q  = '0;
            temp_div_q  = '0;
            soil_lvl_q  = LVL_OK;
            cur_lvl_q   = LVL_OK;
            temp_lvl_q  = LVL_OK;
            lamp_q      = '0;
            predicted_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SOIL_WARN: soil_warn_r = i_cfg_wdata[SOIL_W-1:0];
                    REG_SOIL_CRIT: soil_crit_r = i_cfg_wdata[SOIL_W-1:0];
                    REG_SOIL_REC:  soil_rec_r  = i_cfg_wdata[SOIL_W-1:0];
                    REG_CUR_WARN:  cur_warn_r  = i_cfg_wdata[CUR_W-1:0];
                    REG_CUR_CRIT:  cur_crit_r  = i_cfg_wdata[CUR_W-1:0];
                    REG_TEMP_WARN: temp_warn_r = i_cfg_wdata[TEMP_W-1:0];
                    REG_TEMP_CRIT: temp_crit_r = i_cfg_wdata[TEMP_W-1:0];
                    REG_TEMP_REC:  temp_rec_r  = i_cfg_wdata[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_status(i_s_tuser, i_s_tdata[15:0], i_s_tdata[22:16],
                               $signed(i_s_tdata[32:23]), want);
                predicted_status_q.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_status_q.size() == 0) begin
                    $error("status word with nothing predicted: %h", i_m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_status_q.pop_front();
                    got  = i_m_tdata;
                    check_field("system_state", want.system_state, got.system_state);
                    check_field("fault_bits", want.fault_bits, got.fault_bits);
                    check_field("pump_locked", want.pump_locked, got.pump_locked);
                    check_field("relay_off_pulse", want.relay_off_pulse, got.relay_off_pulse);
                    check_field("yellow_led", want.yellow_led, got.yellow_led);
                    check_field("red_led", want.red_led, got.red_led);
                    check_field("beep_mask", want.beep_mask, got.beep_mask);
                    check_field("soil_level", want.soil_level, got.soil_level);
                    check_field("current_level", want.current_level, got.current_level);
                    check_field("temp_level", want.temp_level, got.temp_level);
                    check_field("pad", want.pad, got.pad);
                end
            end
        end
        o_pending    <= predicted_status_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== test/tb_pump_protection_monitor_unit.sv =====
module tb_pump_protection_monitor_unit;
    import ppm_pkg::*;

    typedef enum int {CUR_OK, CUR_WARN, CUR_CRIT, CUR_RAW} cur_band_t;
    typedef enum int {SET_TYPICAL, SET_LOW, SET_HIGH, SET_SPREAD, SET_RAW, SET_DEFAULT}
        setting_kind_t;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              s_axis_tuser  = CMD_TICK;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_wdata   = '0;

    int pending_words;
    int checker_fails;
    int send_idle_pct = 29;
    int recv_idle_pct = 47;
    int random_sent   = 0;
    int cfg_val[8];

    pump_protection_monitor_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    ppm_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending_words),
        .o_fail_count (checker_fails)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_word(input logic cmd, input logic [CUR_W-1:0] cur,
                             input logic [SOIL_W-1:0] soil, input logic [TEMP_W-1:0] temp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, temp, soil, cur};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // hold the strobe high across back-to-back writes, drop it once at the end
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value[CFG_DW-1:0];
        if (addr <= REG_TEMP_REC) cfg_val[addr] = value;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input setting_kind_t kind);
        int sw, sc, sr, cw, cc, tw, tc, tr;
        case (kind)
            SET_TYPICAL: begin
                sr = $urandom_range(20, 60);
                sw = sr + $urandom_range(20);
                sc = sw + $urandom_range(20);
                cw = $urandom_range(100, 20000);
                cc = cw + $urandom_range(1, 10000);
                tr = int'($urandom_range(200)) - 100;
                tw = tr + $urandom_range(20);
                tc = tw + $urandom_range(20);
            end
            SET_LOW: begin
                sw = 0; sc = 0; sr = 0; cw = 0; cc = 0;
                tw = -512; tc = -512; tr = -512;
            end
            SET_HIGH: begin
                sw = 100; sc = 100; sr = 100; cw = 32768; cc = 32768;
                tw = 511; tc = 511; tr = 511;
            end
            SET_SPREAD: begin
                sw = $urandom_range(100); sc = $urandom_range(100); sr = $urandom_range(100);
                cw = $urandom_range(32768); cc = $urandom_range(32768);
                tw = int'($urandom_range(1023)) - 512;
                tc = int'($urandom_range(1023)) - 512;
                tr = int'($urandom_range(1023)) - 512;
            end
            SET_RAW: begin
                // beyond the documented ranges, compared at full width
                sw = $urandom_range(127); sc = $urandom_range(127); sr = $urandom_range(127);
                cw = $urandom_range(65535); cc = $urandom_range(65535);
                tw = int'($urandom_range(1023)) - 512;
                tc = int'($urandom_range(1023)) - 512;
                tr = int'($urandom_range(1023)) - 512;
            end
            default: begin
                sw = RST_SOIL_WARN; sc = RST_SOIL_CRIT; sr = RST_SOIL_REC;
                cw = RST_CUR_WARN; cc = RST_CUR_CRIT;
                tw = RST_TEMP_WARN; tc = RST_TEMP_CRIT; tr = RST_TEMP_REC;
            end
        endcase
        write_reg(REG_SOIL_WARN, sw);
        write_reg(REG_SOIL_CRIT, sc);
        write_reg(REG_SOIL_REC, sr);
        write_reg(REG_CUR_WARN, cw);
        write_reg(REG_CUR_CRIT, cc);
        write_reg(REG_TEMP_WARN, tw);
        write_reg(REG_TEMP_CRIT, tc);
        write_reg(REG_TEMP_REC, tr);
        // unused index: must leave every threshold alone
        write_reg(4'(REG_TEMP_REC + 1 + $urandom_range(7)), $urandom_range(65535));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CUR_W-1:0] pick_current(input cur_band_t band);
        int lo, hi, mag;
        lo = 1;
        hi = 0;
        case (band)
            CUR_OK:   begin lo = 0; hi = cfg_val[REG_CUR_WARN]; end
            CUR_WARN: begin lo = cfg_val[REG_CUR_WARN] + 1; hi = cfg_val[REG_CUR_CRIT]; end
            CUR_CRIT: begin lo = cfg_val[REG_CUR_CRIT] + 1; hi = 32768; end
            default: ;
        endcase
        if (hi > 32768) hi = 32768;
        if (lo > hi) return CUR_W'($urandom);
        mag = lo + $urandom_range(hi - lo);
        return $urandom_range(1) ? CUR_W'(-mag) : CUR_W'(mag);
    endfunction

    function automatic logic [SOIL_W-1:0] pick_soil();
        int anchor[3];
        int v;
        anchor = '{cfg_val[REG_SOIL_WARN], cfg_val[REG_SOIL_CRIT], cfg_val[REG_SOIL_REC]};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = anchor[$urandom_range(2)] + int'($urandom_range(4)) - 2;
            5, 6, 7:       v = $urandom_range(100);
            default:       v = $urandom_range(127);
        endcase
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return SOIL_W'(v);
    endfunction

    function automatic logic [TEMP_W-1:0] pick_temp();
        int anchor[3];
        int v;
        anchor = '{cfg_val[REG_TEMP_WARN], cfg_val[REG_TEMP_CRIT], cfg_val[REG_TEMP_REC]};
        if ($urandom_range(1)) begin
            v = anchor[$urandom_range(2)] + int'($urandom_range(4)) - 2;
        end else begin
            v = int'($urandom_range(1023)) - 512;
        end
        if (v < -512) v = -512;
        if (v > 511) v = 511;
        return TEMP_W'(v);
    endfunction

    task automatic send_tick(input logic cmd, input cur_band_t band);
        if (random_sent < 400) begin
            send_idle_pct = 29;
            recv_idle_pct = 47;
        end else if (random_sent < 800) begin
            send_idle_pct = 47;
            recv_idle_pct = 29;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        send_word(cmd, pick_current(band), pick_soil(), pick_temp());
        random_sent++;
    endtask

    task automatic run_random(input int count);
        int        done;
        int        len;
        cur_band_t band;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 6) begin
                send_tick(CMD_RESET, CUR_RAW);
                done++;
            end else begin
                band = cur_band_t'($urandom_range(3));
                len  = $urandom_range(1, 12);
                repeat (len) begin
                    send_tick(($urandom_range(99) < 5) ? CMD_RESET : CMD_TICK, band);
                    done++;
                end
            end
        end
    endtask

    initial begin
        cfg_val[REG_SOIL_WARN] = RST_SOIL_WARN;
        cfg_val[REG_SOIL_CRIT] = RST_SOIL_CRIT;
        cfg_val[REG_SOIL_REC]  = RST_SOIL_REC;
        cfg_val[REG_CUR_WARN]  = RST_CUR_WARN;
        cfg_val[REG_CUR_CRIT]  = RST_CUR_CRIT;
        cfg_val[REG_TEMP_WARN] = RST_TEMP_WARN;
        cfg_val[REG_TEMP_CRIT] = RST_TEMP_CRIT;
        cfg_val[REG_TEMP_REC]  = RST_TEMP_REC;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass at reset thresholds
        send_word(CMD_RESET, 16'h1234, 7'd5, 10'd5);     // nothing pending: no change
        send_word(CMD_TICK, 16'h8000, 7'd0, 10'd0);      // most negative current
        send_word(CMD_TICK, 16'h7fff, 7'd100, 10'h1ff);  // critical while reset pending
        send_word(CMD_RESET, 16'h0000, 7'd0, 10'd0);     // clear overcurrent latch
        send_word(CMD_TICK, 16'd2000, 7'd0, 10'd0);
        send_word(CMD_TICK, CUR_W'(-2000), 7'd0, 10'd0);
        send_word(CMD_TICK, 16'd2000, 7'd0, 10'd0);      // persistence reached
        send_word(CMD_TICK, 16'd2500, 7'd0, 10'd0);      // warn at critical boundary
        send_word(CMD_TICK, 16'd1500, 7'd0, 10'd0);      // ok at warn boundary
        send_word(CMD_TICK, 16'd0, 7'd0, 10'd0);
        send_word(CMD_TICK, 16'd1501, 7'd0, 10'd0);
        send_word(CMD_TICK, 16'hffff, 7'd127, 10'd0);    // soil check: overwater
        for (int k = 0; k < 9; k++) begin
            send_word(CMD_TICK, k[0] ? 16'hffff : 16'h0000, 7'd127, 10'h200);
        end
        send_word(CMD_TICK, 16'd0, 7'd70, 10'h1ff);      // soil recovers, overheat
        send_word(CMD_RESET, 16'hffff, 7'd127, 10'h3ff); // overheat needs no reset
        drain_results();

        for (int k = SET_TYPICAL; k <= SET_DEFAULT; k++) begin
            load_settings(setting_kind_t'(k));
            // long warn run to saturate the persistence count
            if (k == SET_TYPICAL) repeat (270) send_tick(CMD_TICK, CUR_WARN);
            run_random(150);
            drain_results();
        end

        if (checker_fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
